[hw/rtl/gfaes_pkg.sv]
// ----------------------------------------------------------------------------
// gfaes_pkg: shared types, constants and functions for the GF(2^8) unit
// Operation codes, the affine constants of the AES S-box and the linear
// helpers (squaring, rotations, affine maps) that the datapath stages use.
// ----------------------------------------------------------------------------
`default_nettype none

package gfaes_pkg;

    // Operation codes carried with each transaction
    typedef enum logic [1:0] {
        KIND_MUL      = 2'd0,
        KIND_INV      = 2'd1,
        KIND_SBOX     = 2'd2,
        KIND_INV_SBOX = 2'd3
    } kind_t;

    localparam logic [7:0] AFFINE_CONST     = 8'h63;
    localparam logic [7:0] INV_AFFINE_CONST = 8'h05;
    localparam logic [7:0] REDUCE_CONST     = 8'h1b;
    localparam logic [8:0] FIELD_POLY       = 9'h11b;

    // Rotate a byte left by a constant amount
    function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
        logic [15:0] w;
        w = {v, v} << n;
        return w[15:8];
    endfunction

    // Square in GF(2^8): spread the bits, then fold the high part back
    function automatic logic [7:0] gf_sq(input logic [7:0] x);
        logic [14:0] w;
        w = '0;
        for (int i = 0; i < 8; i++) begin
            w[2 * i] = x[i];
        end
        for (int k = 14; k >= 8; k--) begin
            if (w[k]) begin
                w = w ^ (15'(FIELD_POLY) << (k - 8));
            end
        end
        return w[7:0];
    endfunction

    // Raise to the sixteenth power (four squarings)
    function automatic logic [7:0] gf_pow16(input logic [7:0] x);
        return gf_sq(gf_sq(gf_sq(gf_sq(x))));
    endfunction

    // Forward AES affine transform
    function automatic logic [7:0] affine_fwd(input logic [7:0] x);
        return x ^ rotl8(x, 1) ^ rotl8(x, 2) ^ rotl8(x, 3) ^ rotl8(x, 4) ^ AFFINE_CONST;
    endfunction

    // Inverse AES affine transform
    function automatic logic [7:0] affine_inv(input logic [7:0] s);
        return rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ INV_AFFINE_CONST;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/gfaes_mul.sv]
// ----------------------------------------------------------------------------
// gfaes_mul: combinational GF(2^8) multiplier
// Shift-and-add product of two field elements reduced by x^8+x^4+x^3+x+1.
// ----------------------------------------------------------------------------
`default_nettype none

module gfaes_mul (
    input  wire logic [7:0] a,
    input  wire logic [7:0] b,
    output logic      [7:0] p
);

    logic [7:0] acc;
    logic [7:0] mc;

    // Accumulate partial products while doubling the multiplicand
    always_comb begin
        acc = '0;
        mc  = b;
        for (int k = 0; k < 8; k++) begin
            if (a[k]) begin
                acc = acc ^ mc;
            end
            mc = {mc[6:0], 1'b0} ^ (mc[7] ? gfaes_pkg::REDUCE_CONST : 8'h00);
        end
        p = acc;
    end

endmodule

`default_nettype wire

[hw/rtl/gf256_aes_arithmetic_unit.sv]
// Throughput: one transaction per cycle unless m_ready holds off the output; the inverse a^254 is split over
// three multiplier stages (a^3, a^14/a^15, a^254) behind an input stage.
// Reset: aresetn (synchronous, active low) clears all stage valid bits;
// the payload registers are not reset.
// ----------------------------------------------------------------------------
// gf256_aes_arithmetic_unit: pipelined AES GF(2^8) arithmetic
// Multiply, inverse, forward S-box and inverse S-box, one byte per cycle,
// four register stages with valid bits and backpressure on every stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gf256_aes_arithmetic_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_kind,
    input  wire logic [7:0] s_operand_a,
    input  wire logic [7:0] s_operand_b,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic      [7:0] m_result_byte
);

    // Stage registers
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    gfaes_pkg::kind_t     kind1_reg, kind2_reg, kind3_reg;
    logic [7:0]           x1_reg, prod1_reg;
    logic [7:0]           x2_reg, x3_reg, prod2_reg;
    logic [7:0]           x14_reg, x15_reg, prod3_reg;
    logic [7:0]           result_reg;

    // Next values
    logic [7:0]           x1_next, prod1_next;
    logic [7:0]           x2_next, x3_next;
    logic [7:0]           x12, x14_next, x15_next;
    logic [7:0]           x240, inv_val, result_next;
    gfaes_pkg::kind_t     kind_in;

    // Stage enables
    logic                 rdy1, rdy2, rdy3, rdy4;

    // Propagate backpressure: a stage loads when empty or draining
    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    assign kind_in = gfaes_pkg::kind_t'(s_kind);

    // Stage 1: inverse affine for the inverse S-box, full product for multiply
    assign x1_next = (kind_in == gfaes_pkg::KIND_INV_SBOX)
                   ? gfaes_pkg::affine_inv(s_operand_a) : s_operand_a;

    gfaes_mul u_mul_prod (.a(s_operand_a), .b(s_operand_b), .p(prod1_next));

    // Stage 2: x^2 and x^3
    assign x2_next = gfaes_pkg::gf_sq(x1_reg);

    gfaes_mul u_mul_x3 (.a(x2_next), .b(x1_reg), .p(x3_next));

    // Stage 3: x^12, then x^14 and x^15
    assign x12 = gfaes_pkg::gf_sq(gfaes_pkg::gf_sq(x3_reg));

    gfaes_mul u_mul_x14 (.a(x12), .b(x2_reg), .p(x14_next));
    gfaes_mul u_mul_x15 (.a(x12), .b(x3_reg), .p(x15_next));

    // Stage 4: x^240 * x^14 = x^254, then select the result
    assign x240 = gfaes_pkg::gf_pow16(x15_reg);

    gfaes_mul u_mul_inv (.a(x240), .b(x14_reg), .p(inv_val));

    always_comb begin
        unique case (kind3_reg)
            gfaes_pkg::KIND_MUL:      result_next = prod3_reg;
            gfaes_pkg::KIND_INV:      result_next = inv_val;
            gfaes_pkg::KIND_SBOX:     result_next = gfaes_pkg::affine_fwd(inv_val);
            gfaes_pkg::KIND_INV_SBOX: result_next = inv_val;
            default:                  result_next = inv_val;
        endcase
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Payload registers: advance with the stage enable, hold otherwise
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            kind1_reg <= kind_in;
            x1_reg    <= x1_next;
            prod1_reg <= prod1_next;
        end
        if (rdy2) begin
            kind2_reg <= kind1_reg;
            x2_reg    <= x2_next;
            x3_reg    <= x3_next;
            prod2_reg <= prod1_reg;
        end
        if (rdy3) begin
            kind3_reg <= kind2_reg;
            x14_reg   <= x14_next;
            x15_reg   <= x15_next;
            prod3_reg <= prod2_reg;
        end
        if (rdy4) begin
            result_reg <= result_next;
        end
    end

    assign m_valid       = v4_reg;
    assign m_result_byte = result_reg;

    // An empty output stage leaves the whole pipeline free to accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        !v4_reg |-> s_ready)
        else $error("input stalled while output stage is empty");

    // An accepted transaction occupies the first stage next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted transaction lost at stage 1");

    // A stalled middle stage keeps its contents
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !rdy3) |=> (v2_reg && $stable(x2_reg) && $stable(x3_reg)
                               && $stable(kind2_reg)))
        else $error("stage 2 changed while stalled");

    // A stage that stalls implies every later stage is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !rdy2) |-> (v2_reg && v3_reg && v4_reg && !m_ready))
        else $error("stage 1 stalled with a bubble downstream");

endmodule

`default_nettype wire

[tb/gf256_aes_arithmetic_unit_test.sv]
// ----------------------------------------------------------------------------
// gf256_aes_arithmetic_unit_test: self-checking bench for the GF(2^8) unit
// Drives multiply, inverse, forward and inverse S-box transactions through the
// valid/ready input and compares every result byte against a bit-exact
// predictor, under random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module gf256_aes_arithmetic_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] POLY_LOW_BITS   = 8'h1b;
    localparam logic [7:0] SBOX_XOR        = 8'h63;
    localparam logic [7:0] INV_SBOX_XOR    = 8'h05;
    localparam int         RANDOM_OPS      = 1150;
    localparam int         IDLE_PERCENT    = 8;
    localparam int         HOLD_OFF_CYCLES = 200;
    localparam int         HOLD_OFF_AT     = 300;
    localparam int         CALM_FROM       = 600;
    localparam int         CALM_TO         = 850;
    localparam int         DRAIN_CYCLES    = 12;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         REPORT_LIMIT    = 10;

    // ------------------------------------------------------------------
    // Field arithmetic predictor
    // ------------------------------------------------------------------

    // Shift-and-add product, reducing by x^8 + x^4 + x^3 + x + 1
    function automatic logic [7:0] field_product(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (y[i]) begin
                acc = acc ^ x;
            end
            x = {x[6:0], 1'b0} ^ (x[7] ? POLY_LOW_BITS : 8'h00);
        end
        return acc;
    endfunction

    // x^254 by square-and-multiply; zero comes out as zero
    function automatic logic [7:0] field_reciprocal(input logic [7:0] x);
        logic [7:0] acc;
        logic [7:0] power;
        acc = 8'h01;
        power = x;
        for (int i = 0; i < 8; i++) begin
            if (i != 0) begin
                acc = field_product(acc, power);
            end
            power = field_product(power, power);
        end
        return acc;
    endfunction

    function automatic logic [7:0] rot_left(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    function automatic logic [7:0] predict_byte(input gfaes_pkg::kind_t op,
                                                input logic [7:0] a,
                                                input logic [7:0] b);
        logic [7:0] t;
        case (op)
            gfaes_pkg::KIND_MUL: begin
                return field_product(a, b);
            end
            gfaes_pkg::KIND_INV: begin
                return field_reciprocal(a);
            end
            gfaes_pkg::KIND_SBOX: begin
                t = field_reciprocal(a);
                return t ^ rot_left(t, 1) ^ rot_left(t, 2) ^ rot_left(t, 3)
                       ^ rot_left(t, 4) ^ SBOX_XOR;
            end
            default: begin
                t = rot_left(a, 1) ^ rot_left(a, 3) ^ rot_left(a, 6) ^ INV_SBOX_XOR;
                return field_reciprocal(t);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard of result bytes still owed by the unit
    // ------------------------------------------------------------------
    typedef struct {
        gfaes_pkg::kind_t op;
        logic [7:0]       a;
        logic [7:0]       b;
        logic [7:0]       want;
    } owed_byte_t;

    class owed_byte_board;
        owed_byte_t  owed[$];
        int unsigned misses;

        function new();
            misses = 0;
        endfunction

        function void note_operation(input gfaes_pkg::kind_t op, input logic [7:0] a,
                                     input logic [7:0] b);
            owed_byte_t e;
            e.op = op;
            e.a = a;
            e.b = b;
            e.want = predict_byte(op, a, b);
            owed = {owed, e};
        endfunction

        function void check_result(input logic [7:0] got);
            owed_byte_t e;
            if (owed.size() == 0) begin
                if (misses < REPORT_LIMIT) begin
                    $display("%0t: result %h arrived with no transaction pending",
                             $realtime, got);
                end
                misses++;
                return;
            end
            e = owed.pop_front();
            if (got !== e.want) begin
                if (misses < REPORT_LIMIT) begin
                    $display("%0t: %s a=%h b=%h expected %h got %h",
                             $realtime, e.op.name(), e.a, e.b, e.want, got);
                end
                misses++;
            end
        endfunction

        function int unsigned outstanding();
            return owed.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and ports
    // ------------------------------------------------------------------
    logic       aclk;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [1:0] s_kind        = gfaes_pkg::KIND_MUL;
    logic [7:0] s_operand_a   = 8'h00;
    logic [7:0] s_operand_b   = 8'h00;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [7:0] m_result_byte;

    owed_byte_board board     = new();
    int         ops_sent      = 0;
    bit         hold_request  = 1'b0;
    int         quiet_cycles  = 0;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    gf256_aes_arithmetic_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_operand_a   (s_operand_a),
        .s_operand_b   (s_operand_b),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_byte (m_result_byte)
    );

    function automatic bit calm_window();
        return ops_sent >= CALM_FROM && ops_sent < CALM_TO;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: note accepted transactions, check results, run the watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                board.note_operation(gfaes_pkg::kind_t'(s_kind), s_operand_a, s_operand_b);
            end
            if (m_valid && m_ready) begin
                board.check_result(m_result_byte);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, a calm stretch, one long hold-off
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= calm_window() || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one transaction and hold it until the unit takes it
    task automatic send_op(input gfaes_pkg::kind_t op, input logic [7:0] a,
                           input logic [7:0] b);
        while (!calm_window() && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        ops_sent++;
        if (ops_sent == HOLD_OFF_AT) begin
            hold_request = 1'b1;
        end
    endtask

    // Mostly uniform bytes, with the field's corner values mixed in
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(15))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'h80;
            3: return 8'hff;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: multiply corners, zero inputs, reductions, known S-box pairs
        send_op(gfaes_pkg::KIND_MUL,      8'h00, 8'h00);
        send_op(gfaes_pkg::KIND_MUL,      8'h00, 8'hff);
        send_op(gfaes_pkg::KIND_MUL,      8'hff, 8'h00);
        send_op(gfaes_pkg::KIND_MUL,      8'h01, 8'hff);
        send_op(gfaes_pkg::KIND_MUL,      8'hff, 8'hff);
        send_op(gfaes_pkg::KIND_MUL,      8'h80, 8'h02);
        send_op(gfaes_pkg::KIND_MUL,      8'h57, 8'h83);
        send_op(gfaes_pkg::KIND_MUL,      8'h02, 8'h87);
        send_op(gfaes_pkg::KIND_INV,      8'h00, 8'hff);
        send_op(gfaes_pkg::KIND_INV,      8'h01, 8'h00);
        send_op(gfaes_pkg::KIND_INV,      8'h53, 8'h5a);
        send_op(gfaes_pkg::KIND_INV,      8'hff, 8'hff);
        send_op(gfaes_pkg::KIND_INV,      8'h80, 8'h00);
        send_op(gfaes_pkg::KIND_SBOX,     8'h00, 8'hff);
        send_op(gfaes_pkg::KIND_SBOX,     8'h53, 8'h00);
        send_op(gfaes_pkg::KIND_SBOX,     8'hff, 8'ha5);
        send_op(gfaes_pkg::KIND_SBOX,     8'h01, 8'h01);
        send_op(gfaes_pkg::KIND_INV_SBOX, 8'h63, 8'hff);
        send_op(gfaes_pkg::KIND_INV_SBOX, 8'h00, 8'h00);
        send_op(gfaes_pkg::KIND_INV_SBOX, 8'hed, 8'h3c);
        send_op(gfaes_pkg::KIND_INV_SBOX, 8'hff, 8'hff);
        send_op(gfaes_pkg::KIND_INV_SBOX, 8'h52, 8'h80);

        // Random mix of all four operations
        for (int i = 0; i < RANDOM_OPS; i++) begin
            send_op(gfaes_pkg::kind_t'($urandom_range(3)), pick_byte(), pick_byte());
        end
        s_valid <= 1'b0;

        // Drain, then allow for any stray result
        while (board.outstanding() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.misses == 0 && board.outstanding() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

[gf256_aes_arithmetic_unit.f]
hw/rtl/gfaes_pkg.sv
hw/rtl/gfaes_mul.sv
hw/rtl/gf256_aes_arithmetic_unit.sv
tb/gf256_aes_arithmetic_unit_test.sv
